### src/asc_pkg.sv
// Package for the alphabet shift cipher: alphabet table, stage types and lookup helpers.
`default_nettype none
package asc_pkg;

	localparam int unsigned ALPHA_SIZE = 53;
	localparam int unsigned POS_W      = $clog2(ALPHA_SIZE);
	localparam int unsigned SUM_W      = POS_W + 1;
	localparam int unsigned SHIFT_W    = 6;
	localparam int unsigned APB_DW     = 32;
	localparam int unsigned APB_AW     = 3;

	// register indexes, taken from paddr[2]
	localparam logic REG_SHIFT   = 1'b0;
	localparam logic REG_DECRYPT = 1'b1;

	localparam logic [7:0] ALPHA_TAB [ALPHA_SIZE] = '{
		8'h20, "A", "E", "I", "O", "U", "a", "e", "i", "o", "u",
		"B", "C", "D", "F", "G", "H", "J", "K", "L", "M", "N",
		"P", "Q", "R", "S", "T", "V", "W", "X", "Y", "Z",
		"b", "c", "d", "f", "g", "h", "j", "k", "l", "m", "n",
		"p", "q", "r", "s", "t", "v", "w", "x", "y", "z"
	};

	typedef struct packed {
		logic               hit;
		logic [POS_W-1:0]   pos;
	} find_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] shift;
		logic               decrypt;
	} cfg_t;

	typedef struct packed {
		logic [7:0]         ch;
		logic               hit;
		logic [POS_W-1:0]   pos;
	} stage_t;

	typedef struct packed {
		logic [7:0]         ch;
		logic               hit;
	} result_t;

	// table entries are unique, so the matches can simply be OR'ed together
	function automatic find_t alpha_find(input logic [7:0] b);
		find_t r;
		r = '0;
		for (int k = 0; k < ALPHA_SIZE; k++) begin
			if (ALPHA_TAB[k] == b) begin
				r.hit = 1'b1;
				r.pos = r.pos | POS_W'(k);
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] sym_at(input logic [POS_W-1:0] p);
		logic [7:0] r;
		r = 8'h00;
		if (32'(p) < ALPHA_SIZE) begin
			r = ALPHA_TAB[p];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### src/asc_lookup.sv
// Stage 1: finds the byte's position in the alphabet.
`default_nettype none
module asc_lookup (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_in,
	input  wire logic [7:0]      char_in,
	input  wire logic            stall_dn,
	output logic                 stall_up,
	output logic                 valid_s1,
	output asc_pkg::stage_t      data_s1
);
	logic         adv;
	asc_pkg::find_t f;

	assign adv      = !valid_s1 || !stall_dn;
	assign stall_up = !adv;
	assign f        = asc_pkg::alpha_find(char_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_in) begin
			data_s1.ch  <= char_in;
			data_s1.hit <= f.hit;
			data_s1.pos <= f.pos;
		end
	end
endmodule
`default_nettype wire

### src/asc_rotate.sv
// Stage 2: moves the position forward or backward by the shift, modulo the alphabet size.
`default_nettype none
module asc_rotate (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire asc_pkg::cfg_t   cfg,
	input  wire logic            valid_in,
	input  wire asc_pkg::stage_t data_in,
	input  wire logic            stall_dn,
	output logic                 stall_up,
	output logic                 valid_s2,
	output asc_pkg::stage_t      data_s2
);
	localparam logic [asc_pkg::SHIFT_W-1:0] SIZE_SH  = asc_pkg::SHIFT_W'(asc_pkg::ALPHA_SIZE);
	localparam logic [asc_pkg::SUM_W-1:0]   SIZE_SUM = asc_pkg::SUM_W'(asc_pkg::ALPHA_SIZE);

	logic                          adv;
	logic [asc_pkg::SHIFT_W-1:0]   s_red;
	logic [asc_pkg::SUM_W-1:0]     sum;
	logic [asc_pkg::SUM_W-1:0]     np;

	assign adv      = !valid_s2 || !stall_dn;
	assign stall_up = !adv;

	always_comb begin
		// out-of-range shift wraps once
		s_red = (cfg.shift >= SIZE_SH) ? cfg.shift - SIZE_SH : cfg.shift;
		if (cfg.decrypt) begin
			sum = asc_pkg::SUM_W'(data_in.pos) + SIZE_SUM - asc_pkg::SUM_W'(s_red);
		end else begin
			sum = asc_pkg::SUM_W'(data_in.pos) + asc_pkg::SUM_W'(s_red);
		end
		np = (sum >= SIZE_SUM) ? sum - SIZE_SUM : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_in) begin
			data_s2.ch  <= data_in.ch;
			data_s2.hit <= data_in.hit;
			data_s2.pos <= np[asc_pkg::POS_W-1:0];
		end
	end
endmodule
`default_nettype wire

### src/asc_emit.sv
// Stage 3: output register; picks the symbol at the new position or passes the byte through.
`default_nettype none
module asc_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_in,
	input  wire asc_pkg::stage_t data_in,
	input  wire logic            stall_dn,
	output logic                 stall_up,
	output logic                 valid_s3,
	output asc_pkg::result_t     data_s3
);
	logic adv;

	assign adv      = !valid_s3 || !stall_dn;
	assign stall_up = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_in) begin
			data_s3.ch  <= data_in.hit ? asc_pkg::sym_at(data_in.pos) : data_in.ch;
			data_s3.hit <= data_in.hit;
		end
	end
endmodule
`default_nettype wire

### src/alphabet_shift_cipher_unit.sv
// Top level of the alphabet shift cipher: config registers and the three-stage pipeline.
// A word accepted at the input passes the lookup, rotate and emit registers (three stages) to out_valid.
// Throughput: one word per cycle while out_stall is low; each stage refills as it drains.
// Each stage is a skid-free register; the output register takes no new word while a result waits under out_stall.
// Reset (arst_n low) clears all stage valid bits and sets shift and decrypt mode to 0.
// The user must write config over the APB port only while the pipeline is empty; the block does not enforce it.
`default_nettype none
module alphabet_shift_cipher_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input words
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    char_in,
	// result words
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [7:0]                         char_out,
	output logic                               in_alphabet,
	// config port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [asc_pkg::APB_AW-1:0]    paddr,
	input  wire logic [asc_pkg::APB_DW-1:0]    pwdata,
	output logic [asc_pkg::APB_DW-1:0]         prdata,
	output logic                               pready
);
	logic [asc_pkg::SHIFT_W-1:0] shift_q;
	logic                        decrypt_q;
	logic                        wr_en;
	asc_pkg::cfg_t               cfg;

	logic              valid_s1, valid_s2, valid_s3;
	logic              stall_s1, stall_s2, stall_s3;
	asc_pkg::stage_t   data_s1, data_s2;
	asc_pkg::result_t  data_s3;

	// ---- config registers; register index is paddr[2], low bits ignored ----
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= '0;
			decrypt_q <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[2])
				asc_pkg::REG_SHIFT:   shift_q   <= pwdata[asc_pkg::SHIFT_W-1:0];
				asc_pkg::REG_DECRYPT: decrypt_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			asc_pkg::REG_SHIFT:   prdata = asc_pkg::APB_DW'(shift_q);
			asc_pkg::REG_DECRYPT: prdata = asc_pkg::APB_DW'(decrypt_q);
			default:              prdata = '0;
		endcase
	end

	assign cfg.shift   = shift_q;
	assign cfg.decrypt = decrypt_q;

	// ---- pipeline: find position, rotate, emit symbol ----
	asc_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (in_valid),
		.char_in  (char_in),
		.stall_dn (stall_s2),
		.stall_up (stall_s1),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	asc_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_in (valid_s1),
		.data_in  (data_s1),
		.stall_dn (stall_s3),
		.stall_up (stall_s2),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	asc_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_s2),
		.data_in  (data_s2),
		.stall_dn (out_stall),
		.stall_up (stall_s3),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	assign in_stall    = stall_s1;
	assign out_valid   = valid_s3;
	assign char_out    = data_s3.ch;
	assign in_alphabet = data_s3.hit;

	// ---- checks ----
	// backpressure only ever comes from a held result word
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a held result");

	// a flagged word must carry an alphabet symbol
	a_hit_sym: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && in_alphabet) |-> asc_pkg::alpha_find(char_out).hit)
		else $error("flagged word is not an alphabet symbol");

	// a pass-through word must not be an alphabet symbol
	a_miss_sym: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_alphabet) |-> !asc_pkg::alpha_find(char_out).hit)
		else $error("pass-through word is an alphabet symbol");

	// full pipeline under stall holds every stage
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && out_stall) |=> (valid_s1 && valid_s2 && valid_s3))
		else $error("word lost under stall");
endmodule
`default_nettype wire

### sim/tb.sv
// Testbench for alphabet_shift_cipher_unit: random and directed words checked against a predictor.
`default_nettype none
module tb;

	// Alphabet order: space, upper vowels, lower vowels, upper consonants, lower consonants
	localparam int GLYPH_N = 53;
	localparam logic [8*GLYPH_N-1:0] GLYPHS =
		" AEIOUaeiouBCDFGHJKLMNPQRSTVWXYZbcdfghjklmnpqrstvwxyz";
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [asc_pkg::APB_AW-1:0] ADDR_SHIFT   = {asc_pkg::REG_SHIFT, 2'b00};
	localparam logic [asc_pkg::APB_AW-1:0] ADDR_DECRYPT = {asc_pkg::REG_DECRYPT, 2'b00};

	typedef struct packed {
		logic [7:0] ch;
		logic       hit;
	} glyph_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        char_in = 8'h00;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        char_out;
	logic              in_alphabet;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [asc_pkg::APB_AW-1:0] paddr = '0;
	logic [asc_pkg::APB_DW-1:0] pwdata = '0;
	logic [asc_pkg::APB_DW-1:0] prdata;
	logic              pready;

	// Predictor copy of the config registers
	logic [5:0]        key_shift = 6'd0;
	logic              key_decrypt = 1'b0;

	logic [7:0]        plain_bytes[$];     // words waiting for the driver
	glyph_t            awaited_glyphs[$];  // predicted results, oldest first

	int  queued_cnt = 0;
	int  taken_cnt = 0;
	int  result_cnt = 0;
	int  hit_cnt = 0;
	int  decrypt_cnt = 0;
	int  setting_cnt = 0;
	int  errors = 0;
	int  cycles = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	bit  word_taken = 1'b0;
	bit  calm = 1'b0;

	alphabet_shift_cipher_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_in     (char_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.char_out    (char_out),
		.in_alphabet (in_alphabet),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #2 clk = ~clk;

	function automatic logic [7:0] glyph_at(input int k);
		return GLYPHS[8*(GLYPH_N-1-k) +: 8];
	endfunction

	// Rotate one byte through the alphabet; bytes outside it pass through unflagged.
	function automatic glyph_t shift_glyph(input logic [7:0] b, input logic [5:0] sh,
			input logic dec);
		glyph_t r;
		int     pos;
		int     rot;
		int     np;
		pos = -1;
		for (int k = 0; k < GLYPH_N; k++)
			if (pos < 0 && glyph_at(k) == b)
				pos = k;
		// shift values 53..63 fold back into range
		rot = int'(sh);
		if (rot >= GLYPH_N)
			rot -= GLYPH_N;
		if (pos < 0) begin
			r.ch  = b;
			r.hit = 1'b0;
		end else begin
			np = dec ? pos + GLYPH_N - rot : pos + rot;
			if (np >= GLYPH_N)
				np -= GLYPH_N;
			r.ch  = glyph_at(np);
			r.hit = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 100)
			$display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
				result_cnt);
	endtask

	// ---------------------------------------------------------------- driver
	// Holds the current word until taken, then either idles for a burst or sends the next.
	always @(negedge clk) begin : drive_words
		logic       nv;
		logic [7:0] nd;
		nv = in_valid;
		nd = char_in;
		if (arst_n && (!in_valid || word_taken)) begin
			word_taken = 1'b0;
			nv = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (!calm && $urandom_range(0, 7) == 0)
				gap_left = $urandom_range(1, 13) - 1;
			else if (plain_bytes.size() > 0) begin
				nv = 1'b1;
				nd = plain_bytes.pop_front();
			end
		end
		in_valid <= nv;
		char_in  <= nd;
	end

	// Receiver back-pressure in random bursts
	always @(negedge clk) begin : drive_stall
		logic ns;
		ns = 1'b0;
		if (stall_left > 0) begin
			stall_left--;
			ns = 1'b1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			ns = 1'b1;
		end
		out_stall <= ns;
	end

	// ---------------------------------------------------------------- monitor
	// Predict on every accepted input word, check every accepted result word.
	always @(posedge clk) begin : watch_words
		glyph_t want;
		cycles++;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				taken_cnt++;
				word_taken = 1'b1;
				want = shift_glyph(char_in, key_shift, key_decrypt);
				if (want.hit)
					hit_cnt++;
				if (key_decrypt)
					decrypt_cnt++;
				awaited_glyphs.push_back(want);
			end
			if (out_valid && !out_stall) begin
				result_cnt++;
				if (awaited_glyphs.size() == 0)
					report_mismatch("unexpected word", char_out, 0);
				else begin
					want = awaited_glyphs.pop_front();
					if (char_out !== want.ch)
						report_mismatch("char_out", char_out, want.ch);
					if (in_alphabet !== want.hit)
						report_mismatch("in_alphabet", in_alphabet, want.hit);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still pending", cycles,
				awaited_glyphs.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------- config port
	task automatic reg_write(input logic [asc_pkg::APB_AW-1:0] addr,
			input logic [asc_pkg::APB_DW-1:0] data);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic reg_read(input logic [asc_pkg::APB_AW-1:0] addr,
			output logic [asc_pkg::APB_DW-1:0] data);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = addr;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
	endtask

	// Read both registers back and compare the implemented bits
	task automatic check_keys();
		logic [asc_pkg::APB_DW-1:0] rd;
		reg_read(ADDR_SHIFT, rd);
		if (rd[5:0] !== key_shift)
			report_mismatch("shift readback", rd[5:0], key_shift);
		reg_read(ADDR_DECRYPT, rd);
		if (rd[0] !== key_decrypt)
			report_mismatch("decrypt readback", rd[0], key_decrypt);
	endtask

	// Upper data bits get junk; only the register's own bits may stick
	task automatic set_keys(input logic [5:0] sh, input logic dec);
		reg_write(ADDR_SHIFT, ($urandom & ~32'h3f) | asc_pkg::APB_DW'(sh));
		reg_write(ADDR_DECRYPT, ($urandom & ~32'h1) | asc_pkg::APB_DW'(dec));
		key_shift   = sh;
		key_decrypt = dec;
		setting_cnt++;
		check_keys();
	endtask

	task automatic queue_byte(input logic [7:0] b);
		plain_bytes.push_back(b);
		queued_cnt++;
	endtask

	// Mostly alphabet symbols, the rest any byte at all
	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			if ($urandom_range(0, 9) < 7)
				queue_byte(glyph_at($urandom_range(0, GLYPH_N - 1)));
			else
				queue_byte(8'($urandom_range(0, 255)));
	endtask

	// Sender holds off until every word sent so far has come back
	task automatic drain();
		do @(negedge clk); while (taken_cnt < queued_cnt || awaited_glyphs.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- stimulus
	initial begin : stimulus
		logic [7:0] edge_bytes[11];
		logic [5:0] corner_shift[7];
		logic       corner_dec[7];
		edge_bytes = '{8'h00, 8'hFF, 8'h20, "A", "u", "B", "z", "b", "!", 8'h7F, 8'h80};
		corner_shift = '{6'd52, 6'd52, 6'd53, 6'd63, 6'd1, 6'd0, 6'd63};
		corner_dec   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: shift 0, encrypt; non-alphabet bytes and table ends
		setting_cnt++;
		check_keys();
		foreach (edge_bytes[i])
			queue_byte(edge_bytes[i]);
		drain();

		// extreme shifts both ways, with the first and last symbol to force wrap-around
		for (int p = 0; p < 7; p++) begin
			set_keys(corner_shift[p], corner_dec[p]);
			queue_byte(8'h20);
			queue_byte("z");
			queue_random(35);
			drain();
		end

		for (int p = 0; p < 4; p++) begin
			set_keys(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			queue_random(45);
			drain();
		end

		// closing stretch at full rate, no gaps and no back-pressure
		calm = 1'b1;
		set_keys(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
		queue_random(60);
		drain();
		repeat (10) @(posedge clk);

		$display("covered %0d words (%0d in alphabet, %0d decrypting) over %0d key settings",
			result_cnt, hit_cnt, decrypt_cnt, setting_cnt);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
src/asc_pkg.sv
src/asc_lookup.sv
src/asc_rotate.sv
src/asc_emit.sv
src/alphabet_shift_cipher_unit.sv
sim/tb.sv
